// File: sv/m65x_pkg.sv
package m65x_pkg;

    // Operation codes of one decoded instruction.
    typedef enum logic [5:0] {
        K_LDA = 6'd0,  K_LDX = 6'd1,  K_LDY = 6'd2,  K_STA = 6'd3,
        K_STX = 6'd4,  K_STY = 6'd5,  K_TAX = 6'd6,  K_TAY = 6'd7,
        K_TXA = 6'd8,  K_TYA = 6'd9,  K_TSX = 6'd10, K_TXS = 6'd11,
        K_PHA = 6'd12, K_PHP = 6'd13, K_PLA = 6'd14, K_PLP = 6'd15,
        K_AND = 6'd16, K_EOR = 6'd17, K_ORA = 6'd18, K_BIT = 6'd19,
        K_ADC = 6'd20, K_SBC = 6'd21, K_INC = 6'd22, K_INX = 6'd23,
        K_INY = 6'd24, K_DEC = 6'd25, K_DEX = 6'd26, K_DEY = 6'd27,
        K_ASL = 6'd28, K_LSR = 6'd29, K_ROL = 6'd30, K_ROR = 6'd31,
        K_CMP = 6'd32, K_CPX = 6'd33, K_CPY = 6'd34, K_BCC = 6'd35,
        K_BCS = 6'd36, K_BEQ = 6'd37, K_BMI = 6'd38, K_BNE = 6'd39,
        K_BPL = 6'd40, K_BVC = 6'd41, K_BVS = 6'd42, K_JMP = 6'd43,
        K_JSR = 6'd44, K_RTS = 6'd45, K_RTI = 6'd46, K_CLC = 6'd47,
        K_CLD = 6'd48, K_CLI = 6'd49, K_CLV = 6'd50, K_SEC = 6'd51,
        K_SED = 6'd52, K_SEI = 6'd53, K_RSV = 6'd54, K_NOP = 6'd55
    } kind_t;

    // Status bit positions, NV1BDIZC.
    localparam int FL_C = 0;
    localparam int FL_Z = 1;
    localparam int FL_I = 2;
    localparam int FL_D = 3;
    localparam int FL_B = 4;
    localparam int FL_U = 5;
    localparam int FL_V = 6;
    localparam int FL_N = 7;

    localparam logic [7:0] SP_RESET    = 8'hFD;
    localparam logic [7:0] FLAGS_RESET = 8'h24;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_JSR  = 4'b0010,
        ST_PULL = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

endpackage

// File: sv/m65x_ram.sv
module m65x_ram
    #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
    )
    (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: sv/mos6502_execute_unit.sv
// 6502 execute unit.
// Input channel s_*: one decoded instruction per word (kind, operand, address,
// following pc and the accumulator-mode bit for shifts). Output channel m_*:
// one result word per instruction with the next PC, an optional memory write
// and the register file after execution.
// Plain instructions and single pushes complete in the idle state: a new word
// is accepted every cycle while the output register is free or being drained.
// JSR goes on to the JSR state, as its two return bytes go through the one port
// of the stack RAM. Pulls issue one read per byte through that port and its
// registered read, capture each byte in the pull state and end in the finish
// state: PLA and PLP pull one byte, RTS two and RTI three.
// Results are presented from an output register; while the receiver stalls
// the word holds and the next instruction waits unaccepted or in its final state.
// Reset sets A, X, Y to zero, SP to 0xFD and the status to 0x24. The stack
// page reads as zero until written, tracked by per-entry valid bits that
// reset clears at once, so no clearing pass is needed.
module mos6502_execute_unit
    import m65x_pkg::*;
    #(
    parameter int STACK_DEPTH = 256
    )
    (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [5:0]  s_kind,
    input  logic [7:0]  s_operand,
    input  logic [15:0] s_address,
    input  logic [15:0] s_pc,
    input  logic        s_accumulator_mode,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_next_pc,
    output logic        m_write_enable,
    output logic [15:0] m_write_address,
    output logic [7:0]  m_write_data,
    output logic [7:0]  m_acc_out,
    output logic [7:0]  m_x_out,
    output logic [7:0]  m_y_out,
    output logic [7:0]  m_sp_out,
    output logic [7:0]  m_flags_out
    );

    localparam int AW = $clog2(STACK_DEPTH);

    state_t      state_reg, state_next;
    logic [7:0]  a_reg, a_next, x_reg, x_next, y_reg, y_next;
    logic [7:0]  sp_reg, sp_next, p_reg, p_next;
    kind_t       kind_reg, kind_next;
    logic [15:0] addr_reg, addr_next, pc_reg, pc_next;
    logic [1:0]  pidx_reg, pidx_next;
    logic [7:0]  pb_reg [3];
    logic [7:0]  pb_next [3];
    logic [STACK_DEPTH-1:0] sval_reg, sval_next;
    logic        rval_reg;

    logic        mv_reg, mv_next;
    logic [15:0] npc_reg, npc_next, wa_reg, wa_next;
    logic        we_reg, we_next;
    logic [7:0]  wd_reg, wd_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_rdata, rbyte;
    logic          out_free, s_fire;

    m65x_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign out_free = !mv_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign s_fire   = s_valid && s_ready;
    assign rbyte    = rval_reg ? ram_rdata : 8'h00;

    // Return address byte of JSR: pc minus one, high or low byte.
    function automatic logic [7:0] pc_next_m1(input logic [15:0] pc, input logic hi);
        logic [15:0] r;
        r = pc - 16'd1;
        return hi ? r[15:8] : r[7:0];
    endfunction

    // Decode, execute and sequence the stack accesses.
    always_comb begin
        logic [8:0] sum;
        logic [7:0] mop, v;
        logic       take;
        state_next = state_reg;
        a_next = a_reg; x_next = x_reg; y_next = y_reg;
        sp_next = sp_reg; p_next = p_reg;
        kind_next = kind_reg; addr_next = addr_reg; pc_next = pc_reg;
        pidx_next = pidx_reg;
        pb_next = pb_reg;
        sval_next = sval_reg;
        mv_next = mv_reg && !m_ready;
        npc_next = npc_reg; wa_next = wa_reg; we_next = we_reg; wd_next = wd_reg;
        ram_we = 1'b0;
        ram_addr = sp_reg[AW-1:0];
        ram_wdata = 8'h00;
        sum = 9'd0; mop = 8'h00; v = 8'h00; take = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    kind_next = kind_t'(s_kind);
                    addr_next = s_address;
                    pc_next   = s_pc;
                    pidx_next = 2'd0;
                    mv_next   = 1'b1;
                    npc_next  = s_pc;
                    we_next   = 1'b0;
                    wa_next   = 16'h0000;
                    wd_next   = 8'h00;
                    case (s_kind)
                        K_LDA: begin a_next = s_operand; v = s_operand; end
                        K_LDX: begin x_next = s_operand; v = s_operand; end
                        K_LDY: begin y_next = s_operand; v = s_operand; end
                        K_TAX: begin x_next = a_reg; v = a_reg; end
                        K_TAY: begin y_next = a_reg; v = a_reg; end
                        K_TXA: begin a_next = x_reg; v = x_reg; end
                        K_TYA: begin a_next = y_reg; v = y_reg; end
                        K_TSX: begin x_next = sp_reg; v = sp_reg; end
                        K_AND: begin v = a_reg & s_operand; a_next = v; end
                        K_EOR: begin v = a_reg ^ s_operand; a_next = v; end
                        K_ORA: begin v = a_reg | s_operand; a_next = v; end
                        K_INX: begin v = x_reg + 8'd1; x_next = v; end
                        K_INY: begin v = y_reg + 8'd1; y_next = v; end
                        K_DEX: begin v = x_reg - 8'd1; x_next = v; end
                        K_DEY: begin v = y_reg - 8'd1; y_next = v; end
                        default: v = 8'h00;
                    endcase
                    case (s_kind)
                        K_LDA, K_LDX, K_LDY, K_TAX, K_TAY, K_TXA, K_TYA, K_TSX,
                        K_AND, K_EOR, K_ORA, K_INX, K_INY, K_DEX, K_DEY: begin
                            p_next[FL_Z] = (v == 8'h00);
                            p_next[FL_N] = v[7];
                        end
                        K_STA, K_STX, K_STY: begin
                            we_next = 1'b1;
                            wa_next = s_address;
                            wd_next = (s_kind == K_STA) ? a_reg :
                                      (s_kind == K_STX) ? x_reg : y_reg;
                        end
                        K_TXS: sp_next = x_reg;
                        K_PHA, K_PHP: begin
                            ram_we = 1'b1;
                            ram_wdata = (s_kind == K_PHA) ? a_reg : (p_reg | 8'h30);
                            sval_next[sp_reg[AW-1:0]] = 1'b1;
                            sp_next = sp_reg - 8'd1;
                        end
                        K_PLA, K_PLP, K_RTS, K_RTI: begin
                            mv_next = mv_reg && !m_ready;
                            ram_addr = sp_reg[AW-1:0] + AW'(1);
                            sp_next = sp_reg + 8'd1;
                            state_next = ST_PULL;
                        end
                        K_JSR: begin
                            mv_next = mv_reg && !m_ready;
                            ram_we = 1'b1;
                            ram_wdata = pc_next_m1(s_pc, 1'b1);
                            sval_next[sp_reg[AW-1:0]] = 1'b1;
                            sp_next = sp_reg - 8'd1;
                            state_next = ST_JSR;
                        end
                        K_BIT: begin
                            p_next[FL_Z] = ((a_reg & s_operand) == 8'h00);
                            p_next[FL_N] = s_operand[7];
                            p_next[FL_V] = s_operand[6];
                        end
                        K_ADC, K_SBC: begin
                            mop = (s_kind == K_SBC) ? ~s_operand : s_operand;
                            sum = {1'b0, a_reg} + {1'b0, mop} + {8'h00, p_reg[FL_C]};
                            a_next = sum[7:0];
                            p_next[FL_C] = sum[8];
                            p_next[FL_V] = ~(a_reg[7] ^ mop[7]) & (a_reg[7] ^ sum[7]);
                            p_next[FL_Z] = (sum[7:0] == 8'h00);
                            p_next[FL_N] = sum[7];
                        end
                        K_INC, K_DEC: begin
                            v = (s_kind == K_INC) ? s_operand + 8'd1 : s_operand - 8'd1;
                            we_next = 1'b1;
                            wa_next = s_address;
                            wd_next = v;
                            p_next[FL_Z] = (v == 8'h00);
                            p_next[FL_N] = v[7];
                        end
                        K_ASL, K_LSR, K_ROL, K_ROR: begin
                            mop = s_accumulator_mode ? a_reg : s_operand;
                            if (s_kind == K_ASL || s_kind == K_ROL) begin
                                p_next[FL_C] = mop[7];
                                v = {mop[6:0], (s_kind == K_ROL) & p_reg[FL_C]};
                            end else begin
                                p_next[FL_C] = mop[0];
                                v = {(s_kind == K_ROR) & p_reg[FL_C], mop[7:1]};
                            end
                            p_next[FL_Z] = (v == 8'h00);
                            p_next[FL_N] = v[7];
                            if (s_accumulator_mode) begin
                                a_next = v;
                            end else begin
                                we_next = 1'b1;
                                wa_next = s_address;
                                wd_next = v;
                            end
                        end
                        K_CMP, K_CPX, K_CPY: begin
                            mop = (s_kind == K_CMP) ? a_reg :
                                  (s_kind == K_CPX) ? x_reg : y_reg;
                            sum = {1'b0, mop} - {1'b0, s_operand};
                            p_next[FL_C] = !sum[8];
                            p_next[FL_Z] = (sum[7:0] == 8'h00);
                            p_next[FL_N] = sum[7];
                        end
                        K_BCC: take = !p_reg[FL_C];
                        K_BCS: take = p_reg[FL_C];
                        K_BEQ: take = p_reg[FL_Z];
                        K_BMI: take = p_reg[FL_N];
                        K_BNE: take = !p_reg[FL_Z];
                        K_BPL: take = !p_reg[FL_N];
                        K_BVC: take = !p_reg[FL_V];
                        K_BVS: take = p_reg[FL_V];
                        K_JMP: take = 1'b1;
                        K_CLC: p_next[FL_C] = 1'b0;
                        K_CLD: p_next[FL_D] = 1'b0;
                        K_CLI: p_next[FL_I] = 1'b0;
                        K_CLV: p_next[FL_V] = 1'b0;
                        K_SEC: p_next[FL_C] = 1'b1;
                        K_SED: p_next[FL_D] = 1'b1;
                        K_SEI: p_next[FL_I] = 1'b1;
                        default: take = 1'b0;
                    endcase
                    if (take) begin
                        npc_next = s_address;
                    end
                end
            end
            ST_JSR: begin
                // Second return byte and the result word.
                if (out_free) begin
                    ram_we = 1'b1;
                    ram_wdata = pc_next_m1(pc_reg, 1'b0);
                    sval_next[sp_reg[AW-1:0]] = 1'b1;
                    sp_next = sp_reg - 8'd1;
                    mv_next = 1'b1;
                    npc_next = addr_reg;
                    we_next = 1'b0; wa_next = 16'h0000; wd_next = 8'h00;
                    state_next = ST_IDLE;
                end
            end
            ST_PULL: begin
                // Capture the byte read last cycle; issue the next read or move to the finish state.
                pb_next[pidx_reg] = rbyte;
                pidx_next = pidx_reg + 2'd1;
                if ((kind_reg == K_RTS && pidx_reg == 2'd0) ||
                    (kind_reg == K_RTI && pidx_reg != 2'd2)) begin
                    ram_addr = sp_reg[AW-1:0] + AW'(1);
                    sp_next = sp_reg + 8'd1;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    npc_next = pc_reg;
                    we_next = 1'b0; wa_next = 16'h0000; wd_next = 8'h00;
                    case (kind_reg)
                        K_PLA: begin
                            a_next = pb_reg[0];
                            p_next[FL_Z] = (pb_reg[0] == 8'h00);
                            p_next[FL_N] = pb_reg[0][7];
                        end
                        K_PLP: p_next = (pb_reg[0] & 8'hEF) | 8'h20;
                        K_RTS: npc_next = {pb_reg[1], pb_reg[0]} + 16'd1;
                        K_RTI: begin
                            p_next = (pb_reg[0] & 8'hEF) | 8'h20;
                            npc_next = {pb_reg[2], pb_reg[1]};
                        end
                        default: npc_next = pc_reg;
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            a_reg <= 8'h00; x_reg <= 8'h00; y_reg <= 8'h00;
            sp_reg <= SP_RESET; p_reg <= FLAGS_RESET;
            sval_reg <= '0;
            mv_reg <= 1'b0;
            pidx_reg <= 2'd0;
            rval_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            a_reg <= a_next; x_reg <= x_next; y_reg <= y_next;
            sp_reg <= sp_next; p_reg <= p_next;
            sval_reg <= sval_next;
            mv_reg <= mv_next;
            pidx_reg <= pidx_next;
            rval_reg <= sval_reg[ram_addr];
        end
    end

    // Item and result payload.
    always_ff @(posedge aclk) begin
        kind_reg <= kind_next; addr_reg <= addr_next; pc_reg <= pc_next;
        pb_reg <= pb_next;
        npc_reg <= npc_next; we_reg <= we_next; wa_reg <= wa_next; wd_reg <= wd_next;
    end

    // Register file is sampled into the result word when it is loaded.
    logic [7:0] ao_reg, xo_reg, yo_reg, so_reg, fo_reg;
    always_ff @(posedge aclk) begin
        if (mv_next && out_free) begin
            ao_reg <= a_next; xo_reg <= x_next; yo_reg <= y_next;
            so_reg <= sp_next; fo_reg <= p_next;
        end
    end

    assign m_valid         = mv_reg;
    assign m_next_pc       = npc_reg;
    assign m_write_enable  = we_reg;
    assign m_write_address = wa_reg;
    assign m_write_data    = wd_reg;
    assign m_acc_out       = ao_reg;
    assign m_x_out         = xo_reg;
    assign m_y_out         = yo_reg;
    assign m_sp_out        = so_reg;
    assign m_flags_out     = fo_reg;

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("sequencer state not one-hot");

    a_push_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (s_kind == K_PHA || s_kind == K_PHP)
        |=> sp_reg == $past(sp_reg) - 8'd1) else $error("push did not move SP");

    a_no_write_in_pull: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PULL || state_reg == ST_FIN) |-> !ram_we)
        else $error("stack write during pull");

    a_unused_flag_set: assert property (@(posedge aclk) disable iff (!aresetn)
        p_reg[FL_U] && !p_reg[FL_B]) else $error("status bits 4/5 corrupted");

endmodule
